/* rtl/core/ptps_pkg.sv */
`timescale 1ns / 1ps

package ptps_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD       = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLDOFF_COUNT   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PREAMBLE_LENGTH = 2'd2;

  localparam logic signed [SAMPLE_WIDTH-1:0] THRESHOLD_RESET       = 16'sd16384;
  localparam logic [COUNT_WIDTH-1:0]         HOLDOFF_COUNT_RESET   = 16'd1;
  localparam logic [COUNT_WIDTH-1:0]         PREAMBLE_LENGTH_RESET = 16'd1;

  // route codes
  localparam logic ROUTE_PREAMBLE = 1'b0;
  localparam logic ROUTE_DATA     = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] threshold;
    logic [COUNT_WIDTH-1:0]         holdoff_count;
    logic [COUNT_WIDTH-1:0]         preamble_length;
  } ptps_cfg_t;

  typedef struct packed {
    logic emit;
    logic route;
    logic last;
  } ptps_result_t;

  typedef struct packed {
    logic in_preamble;
    logic before_first;
  } ptps_status_t;

endpackage

/* rtl/core/peak_triggered_preamble_splitter.sv */
`timescale 1ns / 1ps

// channel   dir  signals                      payload
// s_*       in   s_tvalid s_tready s_tdata    sample
// m_*       out  m_tvalid m_tready m_tdata    out_sample; tuser route; tlast preamble_end
// cfg_*     in   cfg_valid cfg_ready          cfg_index, cfg_data
//
// one sample per cycle sustained while m_tready does not stall; a sample passes
// an input register, the compare and counter update, then the output register
// the peak/holdoff state advances when a sample leaves the input register
// m_tready low stalls only when the output register is full and the sample
// in the input register produces a result; dropped samples never stall
// synchronous reset restores register defaults and search state

module peak_triggered_preamble_splitter import ptps_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [SAMPLE_WIDTH-1:0]    s_tdata,   // [15:0] sample
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [SAMPLE_WIDTH-1:0]    m_tdata,   // [15:0] out_sample
  output logic                       m_tuser,   // [0] route
  output logic                       m_tlast,   // preamble_end
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]    cfg_data
);

  ptps_cfg_t    cfg;
  ptps_result_t result;
  ptps_status_t status;

  logic                           in_valid;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic                           out_valid;
  logic [SAMPLE_WIDTH-1:0]        out_sample;
  logic                           out_route;
  logic                           out_last;
  logic                           advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold       <= THRESHOLD_RESET;
      cfg.holdoff_count   <= HOLDOFF_COUNT_RESET;
      cfg.preamble_length <= PREAMBLE_LENGTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD:       cfg.threshold       <= $signed(cfg_data);
        REG_HOLDOFF_COUNT:   cfg.holdoff_count   <= COUNT_WIDTH'(cfg_data);
        REG_PREAMBLE_LENGTH: cfg.preamble_length <= COUNT_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // a held sample moves on if it makes no result or the output slot frees up
  assign advance  = in_valid && (!result.emit || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= $signed(s_tdata);
    end
  end

  ptps_detect u_detect (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (in_sample),
    .cfg    (cfg),
    .result (result),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_sample <= in_sample;
      out_route  <= result.route;
      out_last   <= result.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_sample;
  assign m_tuser  = out_route;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_last_is_preamble: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == ROUTE_PREAMBLE))
    else $error("preamble end flagged on a data transfer");

  a_data_after_first: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ROUTE_DATA) |-> !status.before_first)
    else $error("data transfer before the first preamble");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_sample)))
    else $error("held sample lost while stalled");

  // a pending preamble transfer that is not the last one keeps the run open
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ROUTE_PREAMBLE && !m_tlast) |-> status.in_preamble)
    else $error("preamble run closed before its last transfer");
`endif

endmodule

/* rtl/core/ptps_detect.sv */
`timescale 1ns / 1ps

module ptps_detect import ptps_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  ptps_cfg_t                      cfg,
  output ptps_result_t                   result,
  output ptps_status_t                   status
);

  logic                           in_preamble, in_preamble_next;
  logic                           before_first, before_first_next;
  logic signed [SAMPLE_WIDTH-1:0] peak_value, peak_value_next;
  logic [COUNT_WIDTH-1:0]         holdoff_left, holdoff_left_next;
  logic [COUNT_WIDTH-1:0]         preamble_left, preamble_left_next;

  logic                   new_peak;
  logic                   peak_armed;
  logic [COUNT_WIDTH-1:0] holdoff_dec;
  logic [COUNT_WIDTH-1:0] preamble_dec;

  assign new_peak     = (sample >= cfg.threshold) && (sample >= peak_value);
  assign peak_armed   = peak_value >= cfg.threshold;
  assign holdoff_dec  = holdoff_left - COUNT_WIDTH'(1);
  assign preamble_dec = preamble_left - COUNT_WIDTH'(1);

  always_comb begin
    in_preamble_next   = in_preamble;
    before_first_next  = before_first;
    peak_value_next    = peak_value;
    holdoff_left_next  = holdoff_left;
    preamble_left_next = preamble_left;
    result.emit  = 1'b1;
    result.route = ROUTE_DATA;
    result.last  = 1'b0;
    if (!in_preamble) begin
      if (new_peak) begin
        peak_value_next   = sample;
        holdoff_left_next = cfg.holdoff_count;
      end else if (peak_armed) begin
        holdoff_left_next = holdoff_dec;
        if (holdoff_dec == '0) begin
          in_preamble_next = 1'b1;
        end
      end
      // searching samples ahead of the first preamble are dropped
      result.emit = !before_first;
    end else begin
      before_first_next = 1'b0;
      result.route      = ROUTE_PREAMBLE;
      preamble_left_next = preamble_dec;
      if (preamble_dec == '0) begin
        preamble_left_next = cfg.preamble_length;
        peak_value_next    = '0;
        in_preamble_next   = 1'b0;
        result.last        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_preamble   <= 1'b0;
      before_first  <= 1'b1;
      peak_value    <= '0;
      holdoff_left  <= HOLDOFF_COUNT_RESET;
      preamble_left <= PREAMBLE_LENGTH_RESET;
    end else if (step) begin
      in_preamble   <= in_preamble_next;
      before_first  <= before_first_next;
      peak_value    <= peak_value_next;
      holdoff_left  <= holdoff_left_next;
      preamble_left <= preamble_left_next;
    end
  end

  assign status.in_preamble  = in_preamble;
  assign status.before_first = before_first;

`ifndef SYNTHESIS
  // once a preamble has run, the drop phase never comes back
  a_first_sticky: assert property (@(posedge clk) disable iff (rst)
    !before_first |=> !before_first)
    else $error("before_first set again after a preamble");

  // a flagged last sample always leaves the block searching with a cleared peak
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (step && result.last) |=> (!in_preamble && peak_value == '0))
    else $error("preamble end did not return to search");

  // every preamble sample is forwarded on the preamble route
  a_preamble_emits: assert property (@(posedge clk) disable iff (rst)
    in_preamble |-> (result.emit && result.route == ROUTE_PREAMBLE))
    else $error("preamble sample not routed to the preamble output");
`endif

endmodule
